// ===== design/plre_pkg.sv =====
// plre_pkg: shared types, constants and arithmetic helpers for the ramp generator
// no dependencies; imported by every design file
package plre_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int VAL_W   = 32;
  localparam int FRAME_W = 32;
  localparam int TIME_W  = 32;
  localparam int SUM_W   = 40;
  localparam int FPM_W   = 24;
  localparam int SLOPE_W = 48;
  localparam int PROD_W  = 64;
  localparam int MULB_W  = 32;

  localparam int MUL_STEPS = MULB_W;
  localparam int DIV_STEPS = SLOPE_W;
  localparam int MSTEP_W   = $clog2(MUL_STEPS + 1);
  localparam int DSTEP_W   = $clog2(DIV_STEPS + 1);

  localparam logic [FPM_W-1:0] FPM_RESET = FPM_W'(3145728);

  typedef logic [1:0] action_t;
  localparam action_t ACT_TICK   = 2'd0;
  localparam action_t ACT_CLEAR  = 2'd1;
  localparam action_t ACT_APPEND = 2'd2;
  localparam action_t ACT_SEEK   = 2'd3;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_APP_L1,
    ST_APP_W1,
    ST_APP_L2,
    ST_APP_W2,
    ST_SEEK_L,
    ST_SEEK_W,
    ST_SCAN_RD,
    ST_SCAN_CK,
    ST_FETCH,
    ST_LOAD,
    ST_DIV_L,
    ST_DIV_W,
    ST_TK_RD,
    ST_TK_LD,
    ST_TK_MW,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [FRAME_W-1:0]      first_fr;
    logic [FRAME_W-1:0]      last_fr;
    logic signed [VAL_W-1:0] target;
  } seg_entry_t;

  // saturating add of a time step onto the running ms sum
  function automatic logic [SUM_W-1:0] sat_time_add(input logic [SUM_W-1:0] sum,
                                                    input logic [TIME_W-1:0] t);
    logic [SUM_W:0] s;
    s = {1'b0, sum} + {{(SUM_W + 1 - TIME_W){1'b0}}, t};
    if (s[SUM_W]) begin
      return '1;
    end
    return s[SUM_W-1:0];
  endfunction

  // round product of ms (q12) and the frame rate (q16) to a frame number
  function automatic logic [FRAME_W-1:0] frame_of(input logic [PROD_W-1:0] p);
    logic [PROD_W:0] r;
    r = {1'b0, p} + (65'd1 << 27);
    if (|r[PROD_W:28+FRAME_W]) begin
      return '1;
    end
    return r[28+FRAME_W-1:28];
  endfunction

  // offset plus rounded (slope * distance) / 2^16, clamped to 32 bits
  function automatic logic signed [VAL_W-1:0] interp(input logic signed [VAL_W-1:0] off,
                                                     input logic [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] q;
    logic signed [PROD_W:0]   s;
    q = $signed(p + 64'h8000) >>> 16;
    s = $signed({{(PROD_W + 1 - VAL_W){off[VAL_W-1]}}, off}) + $signed({q[PROD_W-1], q});
    if (s > 65'sd2147483647) begin
      return 32'sh7fffffff;
    end
    if (s < -65'sd2147483648) begin
      return 32'sh80000000;
    end
    return s[VAL_W-1:0];
  endfunction

endpackage

// ===== design/plre_seg_mem.sv =====
// plre_seg_mem: segment table, one write and one registered read per cycle
// depends on plre_pkg
module plre_seg_mem
  import plre_pkg::*;
(
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  seg_entry_t       wr_data,
  input  logic [IDX_W-1:0] rd_addr,
  output seg_entry_t       rd_data
);

  seg_entry_t mem [TABLE_DEPTH];
  seg_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== design/plre_mul.sv =====
// plre_mul: shift-add multiplier, 64-bit multiplicand by 32-bit multiplier, mod 2^64
// depends on plre_pkg
module plre_mul
  import plre_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [PROD_W-1:0] a,
  input  logic [MULB_W-1:0] b,
  output logic              done,
  output logic [PROD_W-1:0] p
);

  logic [PROD_W-1:0]  acc_r, acc_nxt;
  logic [PROD_W-1:0]  a_r, a_nxt;
  logic [MULB_W-1:0]  b_r, b_nxt;
  logic [MSTEP_W-1:0] cnt_r, cnt_nxt;
  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;

  always_comb begin
    acc_nxt  = acc_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      acc_nxt  = '0;
      a_nxt    = a;
      b_nxt    = b;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (b_r[0]) begin
        acc_nxt = acc_r + a_r;
      end
      a_nxt   = a_r << 1;
      b_nxt   = b_r >> 1;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == MSTEP_W'(MUL_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
  end

  assign done = done_r;
  assign p    = acc_r;

endmodule

// ===== design/plre_div.sv =====
// plre_div: restoring divider for the slope, one quotient bit per cycle
// depends on plre_pkg
module plre_div
  import plre_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic                      neg,
  input  logic [SLOPE_W-1:0]        mag,
  input  logic [FRAME_W-1:0]        den,
  output logic                      done,
  output logic signed [SLOPE_W-1:0] q
);

  logic [SLOPE_W-1:0] quo_r, quo_nxt;
  logic [FRAME_W-1:0] rem_r, rem_nxt;
  logic [FRAME_W-1:0] den_r, den_nxt;
  logic [DSTEP_W-1:0] cnt_r, cnt_nxt;
  logic               neg_r, neg_nxt;
  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [FRAME_W:0]   trial;
  logic               fits;

  assign trial = {rem_r, quo_r[SLOPE_W-1]};
  assign fits  = trial >= {1'b0, den_r};

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    neg_nxt  = neg_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = mag;
      rem_nxt  = '0;
      den_nxt  = den;
      neg_nxt  = neg;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = fits ? FRAME_W'(trial - {1'b0, den_r}) : trial[FRAME_W-1:0];
      quo_nxt = {quo_r[SLOPE_W-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DSTEP_W'(DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
  end

  // sign and clamp to the 48-bit signed range
  always_comb begin
    if (neg_r) begin
      if (quo_r > {1'b1, {(SLOPE_W - 1){1'b0}}}) begin
        q = {1'b1, {(SLOPE_W - 1){1'b0}}};
      end else begin
        q = -$signed(quo_r);
      end
    end else begin
      if (quo_r[SLOPE_W-1]) begin
        q = {1'b0, {(SLOPE_W - 1){1'b1}}};
      end else begin
        q = $signed(quo_r);
      end
    end
  end

  assign done = done_r;

endmodule

// ===== design/piecewise_linear_ramp_generator.sv =====
// piecewise_linear_ramp_generator: breakpoint envelope generator, top level
// depends on plre_pkg, plre_seg_mem, plre_mul, plre_div
//
// channel  direction  handshake          payload
// in       input      in_valid/in_stall  action, delay_time, target_value, ramp_time, seek_time
// out      output     out_valid/out_stall sample_value
// cfg      input      cfg_valid/cfg_ready rate
//
// one transaction at a time; in_stall is high while an item is in work
// tick: straight to output on an empty table, else a table read; interpolation adds the 32-step
//   multiplier, a segment's start frame the slope divider, a new segment a fetch and the divider
// append: two 32-step frame conversions, plus the 48-step slope divider for the first segment
// seek: one frame conversion, a scan of every stored segment, then the slope divider
// clear and dropped appends go straight back to idle; synchronous reset, no memory clear
// a finished sample sits in the output register while the next transaction is accepted
module piecewise_linear_ramp_generator
  import plre_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  action_t                   in_action,
  input  logic [TIME_W-1:0]         in_delay_time,
  input  logic signed [VAL_W-1:0]   in_target_value,
  input  logic [TIME_W-1:0]         in_ramp_time,
  input  logic [TIME_W-1:0]         in_seek_time,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [VAL_W-1:0]   out_sample_value,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [FPM_W-1:0]          cfg_rate
);

  state_t state_r, state_nxt;

  // envelope state
  logic [CNT_W-1:0]          seg_count_r, seg_count_nxt;
  logic [FRAME_W-1:0]        frame_r, frame_nxt;
  logic [IDX_W-1:0]          seg_index_r, seg_index_nxt;
  logic signed [VAL_W-1:0]   start_level_r, start_level_nxt;
  logic signed [VAL_W-1:0]   current_level_r, current_level_nxt;
  logic signed [SLOPE_W-1:0] slope_r, slope_nxt;
  logic signed [VAL_W-1:0]   offset_r, offset_nxt;
  logic [SUM_W-1:0]          time_sum_r, time_sum_nxt;
  logic [FRAME_W-1:0]        next_min_r, next_min_nxt;
  logic [FPM_W-1:0]          fpm_r;

  // per-transaction scratch
  action_t                   act_r, act_nxt;
  logic [TIME_W-1:0]         ramp_r, ramp_nxt;
  logic [TIME_W-1:0]         seek_r, seek_nxt;
  logic                      empty_r, empty_nxt;
  logic [FRAME_W-1:0]        start_f_r, start_f_nxt;
  logic [FRAME_W-1:0]        end_f_r, end_f_nxt;
  logic signed [VAL_W-1:0]   tgt_r, tgt_nxt;
  logic [IDX_W-1:0]          scan_k_r, scan_k_nxt;

  logic                      out_valid_r, out_valid_nxt;
  logic signed [VAL_W-1:0]   out_val_r, out_val_nxt;

  // table, multiplier and divider hookup
  logic                      mem_we;
  seg_entry_t                mem_wdata, mem_rdata;
  logic [IDX_W-1:0]          mem_raddr;
  logic                      mul_start, mul_done;
  logic [PROD_W-1:0]         mul_a, mul_p;
  logic [MULB_W-1:0]         mul_b;
  logic                      div_start, div_done, div_neg;
  logic [SLOPE_W-1:0]        div_mag;
  logic signed [SLOPE_W-1:0] div_q;
  logic signed [VAL_W:0]     lvl_diff;
  logic [VAL_W-1:0]          diff_mag;

  logic                      in_acc, out_free, span_pos, has_next, scan_last, full;
  logic                      tk_hold, tk_end, tk_start, in_seg;
  logic [FRAME_W-1:0]        mul_frame, conv_lo;
  state_t                    post_st;

  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign full      = seg_count_r >= CNT_W'(TABLE_DEPTH);
  assign span_pos  = end_f_r > start_f_r;
  assign has_next  = (CNT_W'(seg_index_r) + CNT_W'(1)) < seg_count_r;
  assign scan_last = (CNT_W'(scan_k_r) + CNT_W'(1)) == seg_count_r;
  assign mul_frame = frame_of(mul_p);
  assign conv_lo   = (mul_frame > next_min_r) ? mul_frame : next_min_r;
  assign post_st   = (act_r == ACT_TICK) ? ST_OUT : ST_IDLE;

  // tick classification against the fetched segment
  assign tk_hold  = (frame_r < mem_rdata.first_fr) || (frame_r > mem_rdata.last_fr);
  assign tk_end   = !tk_hold && (frame_r == mem_rdata.last_fr);
  assign tk_start = !tk_hold && !tk_end && (frame_r == mem_rdata.first_fr);
  assign in_seg   = (frame_r >= mem_rdata.first_fr) && (frame_r < mem_rdata.last_fr);

  // slope numerator magnitude and sign
  assign lvl_diff = {tgt_r[VAL_W-1], tgt_r} - {start_level_r[VAL_W-1], start_level_r};
  assign div_neg  = lvl_diff[VAL_W];
  assign diff_mag = div_neg ? VAL_W'(-lvl_diff) : lvl_diff[VAL_W-1:0];
  assign div_mag  = {diff_mag, 16'h0000};
  assign div_start = (state_r == ST_DIV_L) && span_pos;

  // table writes only on append, reads only on tick/seek, so they never overlap
  assign mem_we    = (state_r == ST_APP_W2) && mul_done;
  assign mem_wdata = '{first_fr: start_f_r, last_fr: conv_lo, target: tgt_r};
  assign mem_raddr = (state_r == ST_SCAN_RD) ? scan_k_r : seg_index_r;

  // multiplier operand select: frame conversions or interpolation
  always_comb begin
    mul_start = 1'b0;
    mul_a     = {{(PROD_W - SUM_W){1'b0}}, time_sum_r};
    mul_b     = {{(MULB_W - FPM_W){1'b0}}, fpm_r};
    case (state_r)
      ST_APP_L1, ST_APP_L2: begin
        mul_start = 1'b1;
      end
      ST_SEEK_L: begin
        mul_start = 1'b1;
        mul_a     = {{(PROD_W - TIME_W){1'b0}}, seek_r};
      end
      ST_TK_LD: begin
        mul_start = !tk_hold && !tk_end && !tk_start;
        mul_a     = {{(PROD_W - SLOPE_W){slope_r[SLOPE_W-1]}}, slope_r};
        mul_b     = frame_r - mem_rdata.first_fr;
      end
      default: begin
        mul_start = 1'b0;
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_action)
            ACT_TICK:   state_nxt = (seg_count_r == '0) ? ST_OUT : ST_TK_RD;
            ACT_APPEND: state_nxt = full ? ST_IDLE : ST_APP_L1;
            ACT_SEEK:   state_nxt = ST_SEEK_L;
            default:    state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_APP_L1:  state_nxt = ST_APP_W1;
      ST_APP_W1:  state_nxt = mul_done ? ST_APP_L2 : ST_APP_W1;
      ST_APP_L2:  state_nxt = ST_APP_W2;
      ST_APP_W2: begin
        if (mul_done) begin
          state_nxt = (seg_count_r == '0) ? ST_DIV_L : ST_IDLE;
        end
      end
      ST_SEEK_L:  state_nxt = ST_SEEK_W;
      ST_SEEK_W: begin
        if (mul_done) begin
          state_nxt = (seg_count_r == '0) ? ST_IDLE : ST_SCAN_RD;
        end
      end
      ST_SCAN_RD: state_nxt = ST_SCAN_CK;
      ST_SCAN_CK: state_nxt = scan_last ? ST_FETCH : ST_SCAN_RD;
      ST_FETCH:   state_nxt = ST_LOAD;
      ST_LOAD:    state_nxt = ST_DIV_L;
      ST_DIV_L:   state_nxt = span_pos ? ST_DIV_W : post_st;
      ST_DIV_W:   state_nxt = div_done ? post_st : ST_DIV_W;
      ST_TK_RD:   state_nxt = ST_TK_LD;
      ST_TK_LD: begin
        if (tk_hold) begin
          state_nxt = ST_OUT;
        end else if (tk_end) begin
          state_nxt = has_next ? ST_FETCH : ST_OUT;
        end else if (tk_start) begin
          state_nxt = ST_DIV_L;
        end else begin
          state_nxt = ST_TK_MW;
        end
      end
      ST_TK_MW:   state_nxt = mul_done ? ST_OUT : ST_TK_MW;
      ST_OUT:     state_nxt = out_free ? ST_IDLE : ST_OUT;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // datapath updates
  always_comb begin
    seg_count_nxt     = seg_count_r;
    frame_nxt         = frame_r;
    seg_index_nxt     = seg_index_r;
    start_level_nxt   = start_level_r;
    current_level_nxt = current_level_r;
    slope_nxt         = slope_r;
    offset_nxt        = offset_r;
    time_sum_nxt      = time_sum_r;
    next_min_nxt      = next_min_r;
    act_nxt           = act_r;
    ramp_nxt          = ramp_r;
    seek_nxt          = seek_r;
    empty_nxt         = empty_r;
    start_f_nxt       = start_f_r;
    end_f_nxt         = end_f_r;
    tgt_nxt           = tgt_r;
    scan_k_nxt        = scan_k_r;
    out_valid_nxt     = out_valid_r && out_stall;
    out_val_nxt       = out_val_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          act_nxt = in_action;
          case (in_action)
            ACT_CLEAR: begin
              seg_count_nxt   = '0;
              frame_nxt       = '0;
              seg_index_nxt   = '0;
              start_level_nxt = current_level_r;
              time_sum_nxt    = '0;
              next_min_nxt    = '0;
            end
            ACT_APPEND: begin
              if (!full) begin
                tgt_nxt      = in_target_value;
                ramp_nxt     = in_ramp_time;
                time_sum_nxt = sat_time_add(time_sum_r, in_delay_time);
              end
            end
            ACT_SEEK: begin
              seek_nxt = in_seek_time;
            end
            default: begin
              empty_nxt = (seg_count_r == '0);
            end
          endcase
        end
      end
      ST_APP_W1: begin
        if (mul_done) begin
          start_f_nxt  = conv_lo;
          time_sum_nxt = sat_time_add(time_sum_r, ramp_r);
        end
      end
      ST_APP_W2: begin
        if (mul_done) begin
          end_f_nxt     = conv_lo;
          next_min_nxt  = (&conv_lo) ? conv_lo : conv_lo + 1'b1;
          seg_count_nxt = seg_count_r + 1'b1;
          // only the first segment becomes current on append
          if (seg_count_r == '0) begin
            offset_nxt = start_level_r;
          end
        end
      end
      ST_SEEK_W: begin
        if (mul_done) begin
          frame_nxt  = mul_frame;
          scan_k_nxt = '0;
        end
      end
      ST_SCAN_CK: begin
        // the last containing segment wins
        if (in_seg) begin
          seg_index_nxt = scan_k_r;
        end
        scan_k_nxt = scan_k_r + 1'b1;
      end
      ST_LOAD: begin
        start_f_nxt = mem_rdata.first_fr;
        end_f_nxt   = mem_rdata.last_fr;
        tgt_nxt     = mem_rdata.target;
        offset_nxt  = start_level_r;
      end
      ST_DIV_L: begin
        if (!span_pos) begin
          slope_nxt = '0;
        end
      end
      ST_DIV_W: begin
        if (div_done) begin
          slope_nxt = div_q;
        end
      end
      ST_TK_LD: begin
        if (tk_end) begin
          current_level_nxt = mem_rdata.target;
          if (has_next) begin
            seg_index_nxt   = seg_index_r + 1'b1;
            start_level_nxt = mem_rdata.target;
          end
        end else if (tk_start) begin
          // ramp restarts from wherever the level is now
          offset_nxt  = current_level_r;
          start_f_nxt = mem_rdata.first_fr;
          end_f_nxt   = mem_rdata.last_fr;
          tgt_nxt     = mem_rdata.target;
        end
      end
      ST_TK_MW: begin
        if (mul_done) begin
          current_level_nxt = interp(offset_r, mul_p);
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_val_nxt   = empty_r ? '0 : current_level_r;
          if (!empty_r && !(&frame_r)) begin
            frame_nxt = frame_r + 1'b1;
          end
        end
      end
      default: begin
        out_val_nxt = out_val_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      seg_count_r     <= '0;
      frame_r         <= '0;
      seg_index_r     <= '0;
      start_level_r   <= '0;
      current_level_r <= '0;
      slope_r         <= '0;
      offset_r        <= '0;
      time_sum_r      <= '0;
      next_min_r      <= '0;
      fpm_r           <= FPM_RESET;
      out_valid_r     <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      seg_count_r     <= seg_count_nxt;
      frame_r         <= frame_nxt;
      seg_index_r     <= seg_index_nxt;
      start_level_r   <= start_level_nxt;
      current_level_r <= current_level_nxt;
      slope_r         <= slope_nxt;
      offset_r        <= offset_nxt;
      time_sum_r      <= time_sum_nxt;
      next_min_r      <= next_min_nxt;
      out_valid_r     <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        fpm_r <= cfg_rate;
      end
    end
    act_r     <= act_nxt;
    ramp_r    <= ramp_nxt;
    seek_r    <= seek_nxt;
    empty_r   <= empty_nxt;
    start_f_r <= start_f_nxt;
    end_f_r   <= end_f_nxt;
    tgt_r     <= tgt_nxt;
    scan_k_r  <= scan_k_nxt;
    out_val_r <= out_val_nxt;
  end

  plre_seg_mem u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (seg_count_r[IDX_W-1:0]),
    .wr_data (mem_wdata),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  plre_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  plre_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .neg   (div_neg),
    .mag   (div_mag),
    .den   (end_f_r - start_f_r),
    .done  (div_done),
    .q     (div_q)
  );

  assign in_stall         = (state_r != ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_sample_value = out_val_r;
  assign cfg_ready        = 1'b1;

endmodule

// ===== design/plre_checker.sv =====
// plre_checker: port-level assertions for the ramp generator, bound to the top level
// depends on plre_pkg and piecewise_linear_ramp_generator
module plre_checker
  import plre_pkg::*;
(
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_stall,
  input action_t                 in_action,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic signed [VAL_W-1:0] out_sample_value
);

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_sample_value))
    else $error("result changed while stalled");

  a_rst_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // only tick transactions produce results
  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid && in_valid && !in_stall && in_action != ACT_TICK |=> !out_valid)
    else $error("result without a tick");

  // a new result is only loaded while the input side is busy
  a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared while idle");

endmodule

bind piecewise_linear_ramp_generator plre_checker u_plre_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .in_action        (in_action),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_sample_value (out_sample_value)
);
